>>> hdl/gpio_edge_level_irq_port_core_defines.svh
// ----------------------------------------------------------------------------
// gpio port core assertion macros
// shared property forms for the concurrent checks of the port core
// ----------------------------------------------------------------------------
`ifndef GPIO_EDGE_LEVEL_IRQ_PORT_CORE_DEFINES_SVH
`define GPIO_EDGE_LEVEL_IRQ_PORT_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define GPIOELI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off while arst_n is low
`define GPIOELI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/gpioeli_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpio port package
// widths, command and register codes, and the lane control bundle
// ----------------------------------------------------------------------------
package gpioeli_pkg;

	localparam int PIN_COUNT_DEF = 32;
	localparam int WORD_W        = 32;
	localparam int CNT_W         = 8;
	localparam int VEC_W         = 5;
	localparam int CMD_W         = 3;
	localparam int REG_IDX_W     = 3;

	localparam logic [WORD_W-1:0] OE_N_RST          = '1;
	localparam logic [CNT_W-1:0]  DEBOUNCE_TIME_RST = 8'd30;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK         = 3'd0,
		CMD_SET          = 3'd1,
		CMD_CLEAR        = 3'd2,
		CMD_STATUS_CLEAR = 3'd3,
		CMD_VECTOR       = 3'd4
	} cmd_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_OUTPUT_ENABLE_N = 3'd0,
		REG_RISING_MASK     = 3'd1,
		REG_FALLING_MASK    = 3'd2,
		REG_LOW_LEVEL_MASK  = 3'd3,
		REG_HIGH_LEVEL_MASK = 3'd4,
		REG_DEBOUNCE_MASK   = 3'd5,
		REG_DEBOUNCE_TIME   = 3'd6,
		REG_IRQ_ENABLE_MASK = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic tick;
		logic debounce_en;
		logic rise_en;
		logic fall_en;
		logic low_en;
		logic high_en;
	} lane_ctrl_t;

endpackage

>>> hdl/gpioeli_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpio port channels
// command channel into the core and result channel out of it
// ----------------------------------------------------------------------------
interface gpioeli_cmd_if;
	logic                               valid;
	logic                               ready;
	logic [gpioeli_pkg::CMD_W-1:0]      command;
	logic [gpioeli_pkg::WORD_W-1:0]     pin_sample;
	logic [gpioeli_pkg::WORD_W-1:0]     bit_mask;

	modport source (output valid, output command, output pin_sample, output bit_mask,
		input ready);
	modport sink (input valid, input command, input pin_sample, input bit_mask,
		output ready);
endinterface

interface gpioeli_rsp_if;
	logic                               valid;
	logic                               ready;
	logic [gpioeli_pkg::WORD_W-1:0]     data_in;
	logic [gpioeli_pkg::WORD_W-1:0]     data_out;
	logic [gpioeli_pkg::WORD_W-1:0]     pending;
	logic                               irq;
	logic [gpioeli_pkg::VEC_W-1:0]      vector_pin;
	logic                               vector_valid;

	modport source (output valid, output data_in, output data_out, output pending,
		output irq, output vector_pin, output vector_valid, input ready);
	modport sink (input valid, input data_in, input data_out, input pending,
		input irq, input vector_pin, input vector_valid, output ready);
endinterface

>>> hdl/gpioeli_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpio pin lane
// debounce filter and edge/level event detect for a single pin
// ----------------------------------------------------------------------------
module gpioeli_lane (
	input  logic                               clk,
	input  logic                               arst_n,
	input  gpioeli_pkg::lane_ctrl_t            ctrl,
	input  logic                               sample,
	input  logic [gpioeli_pkg::CNT_W-1:0]      debounce_time,
	output logic                               level,
	output logic                               level_next,
	output logic                               event_hit
);

	logic                              level_q;
	logic [gpioeli_pkg::CNT_W-1:0]     cnt_q;
	logic [gpioeli_pkg::CNT_W-1:0]     cnt_next;

	always_comb begin
		level_next = level_q;
		cnt_next   = '0;
		if (!ctrl.debounce_en) begin
			level_next = sample;
		end else if (sample != level_q) begin
			// change accepted once it has persisted debounce_time+1 ticks
			if (cnt_q >= debounce_time) begin
				level_next = sample;
			end else begin
				cnt_next = cnt_q + 1'b1;
			end
		end
	end

	assign event_hit = (!level_q && level_next && ctrl.rise_en)
		|| (level_q && !level_next && ctrl.fall_en)
		|| (!level_next && ctrl.low_en)
		|| (level_next && ctrl.high_en);

	assign level = level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= 1'b0;
			cnt_q   <= '0;
		end else if (ctrl.tick) begin
			level_q <= level_next;
			cnt_q   <= cnt_next;
		end
	end

endmodule

>>> hdl/gpioeli_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpio vector merge
// picks the lowest pending pin out of the per-lane status bits
// ----------------------------------------------------------------------------
module gpioeli_merge #(
	parameter int PIN_COUNT = gpioeli_pkg::PIN_COUNT_DEF
) (
	input  logic [PIN_COUNT-1:0]               pend,
	output logic [gpioeli_pkg::VEC_W-1:0]      vec_pin,
	output logic                               vec_found
);

	logic [PIN_COUNT-1:0] lowest;

	// isolate the lowest set bit, then encode it
	assign lowest    = pend & (~pend + 1'b1);
	assign vec_found = |pend;

	always_comb begin
		vec_pin = '0;
		for (int i = 0; i < PIN_COUNT; i++) begin
			if (lowest[i]) begin
				vec_pin = vec_pin | gpioeli_pkg::VEC_W'(i);
			end
		end
	end

endmodule

>>> hdl/gpio_edge_level_irq_port_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpio port core with edge and level interrupts
// pin lanes with debounce and event detect, status, output latch and vector
// ----------------------------------------------------------------------------
// Takes one command word per clock unless stalled and returns one result
// word per command in the cycle after acceptance; a new command is taken in
// the same cycle that the previous result leaves. The pin lanes and vector
// encoder compute combinationally, so one register stage sets the rate. A tick
// command samples pin_sample through the per-pin debounce filters and sets
// status bits for enabled edges and levels; set, clear and status-clear
// commands act on bit_mask; the vector command takes the lowest pending
// enabled pin and clears its status bit. Register writes are expected only
// while no result is outstanding. Pins at or above PIN_COUNT read as zero.
`include "gpio_edge_level_irq_port_core_defines.svh"

module gpio_edge_level_irq_port_core #(
	parameter int PIN_COUNT = gpioeli_pkg::PIN_COUNT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [gpioeli_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [gpioeli_pkg::WORD_W-1:0]      cfg_data,
	gpioeli_cmd_if.sink                         cmd,
	gpioeli_rsp_if.source                       rsp
);

	// configuration
	logic [gpioeli_pkg::WORD_W-1:0]  oe_n_q;
	logic [PIN_COUNT-1:0]            rise_mask_q;
	logic [PIN_COUNT-1:0]            fall_mask_q;
	logic [PIN_COUNT-1:0]            low_mask_q;
	logic [PIN_COUNT-1:0]            high_mask_q;
	logic [PIN_COUNT-1:0]            debounce_mask_q;
	logic [gpioeli_pkg::CNT_W-1:0]   debounce_time_q;
	logic [PIN_COUNT-1:0]            irq_en_q;

	// state
	logic [PIN_COUNT-1:0]            latch_q;
	logic [PIN_COUNT-1:0]            status_q;

	// result register
	logic                            rsp_valid_q;
	logic [gpioeli_pkg::WORD_W-1:0]  rsp_data_in_q;
	logic [gpioeli_pkg::WORD_W-1:0]  rsp_data_out_q;
	logic [gpioeli_pkg::WORD_W-1:0]  rsp_pending_q;
	logic                            rsp_irq_q;
	logic [gpioeli_pkg::VEC_W-1:0]   rsp_vec_pin_q;
	logic                            rsp_vec_valid_q;

	logic                            cmd_acc;
	gpioeli_pkg::cmd_t               cmd_code;
	logic [PIN_COUNT-1:0]            cmd_mask;
	logic                            tick_acc;

	logic [PIN_COUNT-1:0]            levels;
	logic [PIN_COUNT-1:0]            levels_next;
	logic [PIN_COUNT-1:0]            events;
	logic [PIN_COUNT-1:0]            pend_cur;
	logic [gpioeli_pkg::VEC_W-1:0]   vec_pin;
	logic                            vec_found;

	logic [PIN_COUNT-1:0]            latch_d;
	logic [PIN_COUNT-1:0]            status_d;
	logic [PIN_COUNT-1:0]            data_in_d;
	logic [PIN_COUNT-1:0]            pend_d;
	logic [gpioeli_pkg::VEC_W-1:0]   vec_pin_d;
	logic                            vec_valid_d;

	assign cmd_acc   = cmd.valid && cmd.ready;
	assign cmd.ready = !rsp_valid_q || rsp.ready;
	assign cmd_code  = gpioeli_pkg::cmd_t'(cmd.command);
	assign cmd_mask  = cmd.bit_mask[PIN_COUNT-1:0];
	assign tick_acc  = cmd_acc && (cmd_code == gpioeli_pkg::CMD_TICK);

	// configuration write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oe_n_q          <= gpioeli_pkg::OE_N_RST;
			rise_mask_q     <= '0;
			fall_mask_q     <= '0;
			low_mask_q      <= '0;
			high_mask_q     <= '0;
			debounce_mask_q <= '0;
			debounce_time_q <= gpioeli_pkg::DEBOUNCE_TIME_RST;
			irq_en_q        <= '0;
		end else if (cfg_wr_en) begin
			unique case (gpioeli_pkg::reg_idx_t'(cfg_index))
				gpioeli_pkg::REG_OUTPUT_ENABLE_N: oe_n_q <= cfg_data;
				gpioeli_pkg::REG_RISING_MASK:     rise_mask_q <= cfg_data[PIN_COUNT-1:0];
				gpioeli_pkg::REG_FALLING_MASK:    fall_mask_q <= cfg_data[PIN_COUNT-1:0];
				gpioeli_pkg::REG_LOW_LEVEL_MASK:  low_mask_q <= cfg_data[PIN_COUNT-1:0];
				gpioeli_pkg::REG_HIGH_LEVEL_MASK: high_mask_q <= cfg_data[PIN_COUNT-1:0];
				gpioeli_pkg::REG_DEBOUNCE_MASK:   debounce_mask_q <= cfg_data[PIN_COUNT-1:0];
				gpioeli_pkg::REG_DEBOUNCE_TIME:
					debounce_time_q <= cfg_data[gpioeli_pkg::CNT_W-1:0];
				gpioeli_pkg::REG_IRQ_ENABLE_MASK: irq_en_q <= cfg_data[PIN_COUNT-1:0];
				default: oe_n_q <= oe_n_q;
			endcase
		end
	end

	// one lane per pin
	for (genvar g = 0; g < PIN_COUNT; g++) begin : g_lane
		gpioeli_pkg::lane_ctrl_t lane_ctrl;

		assign lane_ctrl.tick        = tick_acc;
		assign lane_ctrl.debounce_en = debounce_mask_q[g];
		assign lane_ctrl.rise_en     = rise_mask_q[g];
		assign lane_ctrl.fall_en     = fall_mask_q[g];
		assign lane_ctrl.low_en      = low_mask_q[g];
		assign lane_ctrl.high_en     = high_mask_q[g];

		gpioeli_lane u_lane (
			.clk           (clk),
			.arst_n        (arst_n),
			.ctrl          (lane_ctrl),
			.sample        (cmd.pin_sample[g]),
			.debounce_time (debounce_time_q),
			.level         (levels[g]),
			.level_next    (levels_next[g]),
			.event_hit     (events[g])
		);
	end

	assign pend_cur = status_q & irq_en_q;

	gpioeli_merge #(
		.PIN_COUNT (PIN_COUNT)
	) u_merge (
		.pend      (pend_cur),
		.vec_pin   (vec_pin),
		.vec_found (vec_found)
	);

	always_comb begin
		latch_d     = latch_q;
		status_d    = status_q;
		data_in_d   = levels;
		vec_pin_d   = '0;
		vec_valid_d = 1'b0;
		unique case (cmd_code)
			gpioeli_pkg::CMD_TICK: begin
				data_in_d = levels_next;
				status_d  = status_q | events;
			end
			gpioeli_pkg::CMD_SET: begin
				latch_d = latch_q | cmd_mask;
			end
			gpioeli_pkg::CMD_CLEAR: begin
				latch_d = latch_q & ~cmd_mask;
			end
			gpioeli_pkg::CMD_STATUS_CLEAR: begin
				status_d = status_q & ~cmd_mask;
			end
			gpioeli_pkg::CMD_VECTOR: begin
				if (vec_found) begin
					status_d    = status_q & ~(PIN_COUNT'(1) << vec_pin);
					vec_pin_d   = vec_pin;
					vec_valid_d = 1'b1;
				end
			end
			default: begin
				// unused codes leave the state alone
				latch_d = latch_q;
			end
		endcase
	end

	assign pend_d = status_d & irq_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q     <= '0;
			status_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd_acc) begin
				latch_q  <= latch_d;
				status_q <= status_d;
			end
			if (cmd_acc) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			rsp_data_in_q   <= gpioeli_pkg::WORD_W'(data_in_d);
			rsp_data_out_q  <= gpioeli_pkg::WORD_W'(latch_d);
			rsp_pending_q   <= gpioeli_pkg::WORD_W'(pend_d);
			rsp_irq_q       <= |pend_d;
			rsp_vec_pin_q   <= vec_pin_d;
			rsp_vec_valid_q <= vec_valid_d;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.data_in      = rsp_data_in_q;
	assign rsp.data_out     = rsp_data_out_q;
	assign rsp.pending      = rsp_pending_q;
	assign rsp.irq          = rsp_irq_q;
	assign rsp.vector_pin   = rsp_vec_pin_q;
	assign rsp.vector_valid = rsp_vec_valid_q;

	// direction register is held for software only
	logic oe_n_unused;
	assign oe_n_unused = ^oe_n_q;

	`GPIOELI_ASSERT_NEXT(a_word_gives_result, cmd_acc, rsp.valid, "accepted word gave no result")
	`GPIOELI_ASSERT_NOW(a_vector_cleared, rsp.valid && rsp.vector_valid, !rsp.pending[rsp.vector_pin], "taken vector still pending")
	`GPIOELI_ASSERT_NEXT(a_state_holds, !cmd_acc, $stable(status_q) && $stable(latch_q), "state moved without a word")

endmodule

>>> tb/tb_gpio_edge_level_irq_port_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpio port core regression bench
// drives command words through a short directed table and then several
// randomly configured phases with held, glitching and random pin levels; each
// result word is checked field by field against the table or a port predictor
// ----------------------------------------------------------------------------
module tb_gpio_edge_level_irq_port_core;
	import gpioeli_pkg::*;

	localparam int              PINS       = PIN_COUNT_DEF;
	localparam logic [31:0]     PIN_MASK   = (PINS >= 32) ? '1 : ((32'd1 << PINS) - 32'd1);
	localparam logic [2:0]      CMD_SPARE5 = 3'd5;
	localparam logic [2:0]      CMD_SPARE7 = 3'd7;
	localparam int              QUIET_LIMIT = 1000;
	localparam int              DRILL_LEN  = 34;
	localparam int              PHASES     = 7;

	typedef struct packed {
		logic [31:0] data_in;
		logic [31:0] data_out;
		logic [31:0] pending;
		logic        irq;
		logic [4:0]  vector_pin;
		logic        vector_valid;
	} port_word_t;

	typedef enum bit {ROW_WORD, ROW_REG} row_kind_t;

	typedef struct packed {
		row_kind_t  kind;
		reg_idx_t   reg_sel;
		logic [2:0] op;
		logic [31:0] sample;
		logic [31:0] mask;
		logic       typed;
		port_word_t want;
	} drill_row_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [WORD_W-1:0] cfg_data;

	gpioeli_cmd_if cmd_ch();
	gpioeli_rsp_if rsp_ch();

	gpio_edge_level_irq_port_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd_ch),
		.rsp       (rsp_ch)
	);

	// predictor copy of the port
	logic [31:0] cfg_shadow [0:7];
	logic [31:0] pins_seen;
	logic [31:0] latch_bits;
	logic [31:0] status_bits;
	logic [7:0]  settle_count [0:31];

	port_word_t due_words [$];
	port_word_t head_w;
	int         mismatches = 0;
	int         quiet_cycles = 0;
	bit         steady = 1'b0;

	drill_row_t drill [0:DRILL_LEN-1] = '{
		'{ROW_WORD, REG_OUTPUT_ENABLE_N, CMD_TICK, 32'h0, 32'h0, 1'b1,
			{32'h0, 32'h0, 32'h0, 1'b0, 5'd0, 1'b0}},
		'{ROW_WORD, REG_OUTPUT_ENABLE_N, CMD_SET, 32'h0, 32'hFFFF_FFFF, 1'b1,
			{32'h0, 32'hFFFF_FFFF, 32'h0, 1'b0, 5'd0, 1'b0}},
		'{ROW_WORD, REG_OUTPUT_ENABLE_N, CMD_CLEAR, 32'h0, 32'h0000_FFFF, 1'b1,
			{32'h0, 32'hFFFF_0000, 32'h0, 1'b0, 5'd0, 1'b0}},
		// vector with nothing pending
		'{ROW_WORD, REG_OUTPUT_ENABLE_N, CMD_VECTOR, 32'h0, 32'hFFFF_FFFF, 1'b1,
			{32'h0, 32'hFFFF_0000, 32'h0, 1'b0, 5'd0, 1'b0}},
		// spare codes leave the state alone
		'{ROW_WORD, REG_OUTPUT_ENABLE_N, CMD_SPARE5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
			{32'h0, 32'hFFFF_0000, 32'h0, 1'b0, 5'd0, 1'b0}},
		'{ROW_WORD, REG_OUTPUT_ENABLE_N, CMD_SPARE7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
			{32'h0, 32'hFFFF_0000, 32'h0, 1'b0, 5'd0, 1'b0}},
		'{ROW_WORD, REG_OUTPUT_ENABLE_N, CMD_TICK, 32'hFFFF_FFFF, 32'h0, 1'b1,
			{32'hFFFF_FFFF, 32'hFFFF_0000, 32'h0, 1'b0, 5'd0, 1'b0}},
		'{ROW_WORD, REG_OUTPUT_ENABLE_N, CMD_CLEAR, 32'h0, 32'hFFFF_FFFF, 1'b1,
			{32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0, 5'd0, 1'b0}},
		'{ROW_REG, REG_RISING_MASK, CMD_TICK, 32'h0, 32'hFFFF_FFFF, 1'b0, '0},
		'{ROW_REG, REG_FALLING_MASK, CMD_TICK, 32'h0, 32'hFFFF_FFFF, 1'b0, '0},
		'{ROW_REG, REG_IRQ_ENABLE_MASK, CMD_TICK, 32'h0, 32'hFFFF_FFFF, 1'b0, '0},
		// every pin falls at once
		'{ROW_WORD, REG_OUTPUT_ENABLE_N, CMD_TICK, 32'h0, 32'hFFFF_FFFF, 1'b1,
			{32'h0, 32'h0, 32'hFFFF_FFFF, 1'b1, 5'd0, 1'b0}},
		'{ROW_WORD, REG_OUTPUT_ENABLE_N, CMD_VECTOR, 32'h0, 32'h0, 1'b1,
			{32'h0, 32'h0, 32'hFFFF_FFFE, 1'b1, 5'd0, 1'b1}},
		'{ROW_WORD, REG_OUTPUT_ENABLE_N, CMD_STATUS_CLEAR, 32'h0, 32'h7FFF_FFFE, 1'b1,
			{32'h0, 32'h0, 32'h8000_0000, 1'b1, 5'd0, 1'b0}},
		'{ROW_WORD, REG_OUTPUT_ENABLE_N, CMD_VECTOR, 32'h0, 32'h0, 1'b1,
			{32'h0, 32'h0, 32'h0, 1'b0, 5'd31, 1'b1}},
		'{ROW_WORD, REG_OUTPUT_ENABLE_N, CMD_VECTOR, 32'h0, 32'h0, 1'b1,
			{32'h0, 32'h0, 32'h0, 1'b0, 5'd0, 1'b0}},
		'{ROW_REG, REG_LOW_LEVEL_MASK, CMD_TICK, 32'h0, 32'h0000_000F, 1'b0, '0},
		'{ROW_REG, REG_HIGH_LEVEL_MASK, CMD_TICK, 32'h0, 32'hF000_0000, 1'b0, '0},
		'{ROW_REG, REG_DEBOUNCE_MASK, CMD_TICK, 32'h0, 32'h0000_FF00, 1'b0, '0},
		// zero debounce time, upper data bits must be dropped
		'{ROW_REG, REG_DEBOUNCE_TIME, CMD_TICK, 32'h0, 32'hFFFF_FF00, 1'b0, '0},
		'{ROW_WORD, REG_OUTPUT_ENABLE_N, CMD_TICK, 32'h0000_0F00, 32'h0, 1'b0, '0},
		'{ROW_WORD, REG_OUTPUT_ENABLE_N, CMD_TICK, 32'hA5A5_A5A5, 32'h0, 1'b0, '0},
		'{ROW_WORD, REG_OUTPUT_ENABLE_N, CMD_STATUS_CLEAR, 32'h0, 32'hFFFF_FFFF, 1'b0, '0},
		// levels still held, so status comes straight back
		'{ROW_WORD, REG_OUTPUT_ENABLE_N, CMD_TICK, 32'hA5A5_A5A5, 32'h0, 1'b0, '0},
		'{ROW_REG, REG_DEBOUNCE_MASK, CMD_TICK, 32'h0, 32'hFFFF_FFFF, 1'b0, '0},
		'{ROW_REG, REG_DEBOUNCE_TIME, CMD_TICK, 32'h0, 32'h0000_0002, 1'b0, '0},
		'{ROW_WORD, REG_OUTPUT_ENABLE_N, CMD_TICK, 32'h5A5A_5A5A, 32'h0, 1'b0, '0},
		'{ROW_WORD, REG_OUTPUT_ENABLE_N, CMD_TICK, 32'h5A5A_5A5A, 32'h0, 1'b0, '0},
		'{ROW_WORD, REG_OUTPUT_ENABLE_N, CMD_TICK, 32'h5A5A_5A5A, 32'h0, 1'b0, '0},
		'{ROW_WORD, REG_OUTPUT_ENABLE_N, CMD_TICK, 32'h5A5A_5A5A, 32'h0, 1'b0, '0},
		// a glitch back to the old level is filtered and its counters then reset
		'{ROW_WORD, REG_OUTPUT_ENABLE_N, CMD_TICK, 32'h0, 32'h0, 1'b0, '0},
		'{ROW_WORD, REG_OUTPUT_ENABLE_N, CMD_TICK, 32'h5A5A_5A5A, 32'h0, 1'b0, '0},
		'{ROW_WORD, REG_OUTPUT_ENABLE_N, CMD_VECTOR, 32'h0, 32'h0, 1'b0, '0},
		'{ROW_WORD, REG_OUTPUT_ENABLE_N, CMD_STATUS_CLEAR, 32'h0, 32'hFFFF_FFFF, 1'b0, '0}
	};

	always #6 clk = ~clk;

	function automatic port_word_t compute_port_word(logic [2:0] op, logic [31:0] sample,
			logic [31:0] mask);
		port_word_t  w;
		logic [31:0] prev;
		logic [31:0] next;
		logic [31:0] pend;
		logic [31:0] events;
		w = '0;
		mask = mask & PIN_MASK;
		case (op)
			CMD_TICK: begin
				prev = pins_seen;
				next = '0;
				for (int i = 0; i < PINS; i++) begin
					if (!cfg_shadow[REG_DEBOUNCE_MASK][i]) begin
						next[i] = sample[i];
						settle_count[i] = '0;
					end else if (sample[i] == prev[i]) begin
						next[i] = prev[i];
						settle_count[i] = '0;
					end else if (settle_count[i] >= cfg_shadow[REG_DEBOUNCE_TIME][7:0]) begin
						next[i] = sample[i];
						settle_count[i] = '0;
					end else begin
						next[i] = prev[i];
						settle_count[i] = settle_count[i] + 8'd1;
					end
				end
				next &= PIN_MASK;
				events = (~prev & next & cfg_shadow[REG_RISING_MASK])
					| (prev & ~next & cfg_shadow[REG_FALLING_MASK])
					| (~next & cfg_shadow[REG_LOW_LEVEL_MASK])
					| (next & cfg_shadow[REG_HIGH_LEVEL_MASK]);
				status_bits = (status_bits | events) & PIN_MASK;
				pins_seen = next;
			end
			CMD_SET: latch_bits |= mask;
			CMD_CLEAR: latch_bits &= ~mask;
			CMD_STATUS_CLEAR: status_bits &= ~mask;
			CMD_VECTOR: begin
				pend = status_bits & cfg_shadow[REG_IRQ_ENABLE_MASK] & PIN_MASK;
				if (pend != '0) begin
					for (int i = 31; i >= 0; i--)
						if (pend[i])
							w.vector_pin = 5'(i);
					status_bits[w.vector_pin] = 1'b0;
					w.vector_valid = 1'b1;
				end
			end
			default: ;
		endcase
		latch_bits &= PIN_MASK;
		pend = status_bits & cfg_shadow[REG_IRQ_ENABLE_MASK] & PIN_MASK;
		w.data_in = pins_seen;
		w.data_out = latch_bits;
		w.pending = pend;
		w.irq = (pend != '0);
		return w;
	endfunction

	task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatches++;
		$display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
	endtask

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic issue_word(logic [2:0] op, logic [31:0] sample, logic [31:0] mask,
			logic typed, port_word_t typed_w);
		port_word_t p;
		if (!steady && $urandom_range(0, 99) < 8) begin
			cmd_ch.valid = 1'b0;
			@(negedge clk);
		end
		cmd_ch.command = op;
		cmd_ch.pin_sample = sample;
		cmd_ch.bit_mask = mask;
		cmd_ch.valid = 1'b1;
		do @(posedge clk); while (!cmd_ch.ready);
		p = compute_port_word(op, sample, mask);
		due_words.push_back(typed ? typed_w : p);
		@(negedge clk);
	endtask

	task automatic drain_port();
		cmd_ch.valid = 1'b0;
		while (due_words.size() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		cfg_index = idx;
		cfg_data = val;
		cfg_wr_en = 1'b1;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		cfg_shadow[idx] = (idx == REG_DEBOUNCE_TIME) ? {24'h0, val[7:0]} : val;
	endtask

	always @(negedge clk) begin
		if (arst_n)
			rsp_ch.ready = steady || ($urandom_range(0, 99) >= 8);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (due_words.size() == 0) begin
				flag_mismatch("word with nothing due", rsp_ch.data_in, 32'h0);
			end else begin
				head_w = due_words.pop_front();
				if (rsp_ch.data_in !== head_w.data_in)
					flag_mismatch("data_in", rsp_ch.data_in, head_w.data_in);
				if (rsp_ch.data_out !== head_w.data_out)
					flag_mismatch("data_out", rsp_ch.data_out, head_w.data_out);
				if (rsp_ch.pending !== head_w.pending)
					flag_mismatch("pending", rsp_ch.pending, head_w.pending);
				if (rsp_ch.irq !== head_w.irq)
					flag_mismatch("irq", 32'(rsp_ch.irq), 32'(head_w.irq));
				if (rsp_ch.vector_pin !== head_w.vector_pin)
					flag_mismatch("vector_pin", 32'(rsp_ch.vector_pin),
						32'(head_w.vector_pin));
				if (rsp_ch.vector_valid !== head_w.vector_valid)
					flag_mismatch("vector_valid", 32'(rsp_ch.vector_valid),
						32'(head_w.vector_valid));
			end
		end
	end

	// watchdog on cycles where neither channel moves a word
	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("gpio_edge_level_irq_port_core regression: fail");
			$finish;
		end
	end

	initial begin
		int          count;
		int          keep;
		logic [2:0]  op;
		logic [31:0] pins_now;
		logic [31:0] v;
		int          r;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.command = '0;
		cmd_ch.pin_sample = '0;
		cmd_ch.bit_mask = '0;
		rsp_ch.ready = 1'b0;
		for (int k = 0; k < 8; k++)
			cfg_shadow[k] = '0;
		cfg_shadow[REG_OUTPUT_ENABLE_N] = OE_N_RST;
		cfg_shadow[REG_DEBOUNCE_TIME] = {24'h0, DEBOUNCE_TIME_RST};
		pins_seen = '0;
		latch_bits = '0;
		status_bits = '0;
		for (int k = 0; k < 32; k++)
			settle_count[k] = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < DRILL_LEN; i++) begin
			if (drill[i].kind == ROW_REG) begin
				drain_port();
				write_reg(drill[i].reg_sel, drill[i].mask);
			end else begin
				issue_word(drill[i].op, drill[i].sample, drill[i].mask, drill[i].typed,
					drill[i].want);
			end
		end

		pins_now = pins_seen;
		for (int p = 0; p < PHASES; p++) begin
			drain_port();
			for (int k = 0; k < 8; k++) begin
				v = $urandom;
				case (reg_idx_t'(k))
					REG_DEBOUNCE_TIME: begin
						case (p)
							0: v[7:0] = DEBOUNCE_TIME_RST;
							1, 6: v[7:0] = 8'd0;
							4: v[7:0] = 8'd255;
							5: v[7:0] = 8'd1;
							default: v[7:0] = 8'($urandom_range(0, 3));
						endcase
					end
					REG_DEBOUNCE_MASK: begin
						if (p == 1 || p == 4)
							v = '1;
						else if (p == 0 || p == 6)
							v = '0;
					end
					default: begin
						if (p == 1)
							v = (reg_idx_t'(k) == REG_OUTPUT_ENABLE_N) ? '0 : '1;
						else if (p == 6)
							v = (reg_idx_t'(k) == REG_IRQ_ENABLE_MASK) ? '1 : '0;
					end
				endcase
				write_reg(reg_idx_t'(k), v);
			end
			steady = (p == 5);
			// the long debounce phase needs pins that hold for hundreds of ticks
			keep = (p == 4) ? 99 : 60;
			count = (p == 4) ? 400 : 105;
			for (int n = 0; n < count; n++) begin
				r = $urandom_range(0, 99);
				if (r < 58)
					op = CMD_TICK;
				else if (r < 66)
					op = CMD_SET;
				else if (r < 74)
					op = CMD_CLEAR;
				else if (r < 82)
					op = CMD_STATUS_CLEAR;
				else if (r < 96)
					op = CMD_VECTOR;
				else
					op = 3'($urandom_range(CMD_SPARE5, CMD_SPARE7));
				if (op == CMD_TICK && $urandom_range(0, 99) >= keep) begin
					case ($urandom_range(0, 2))
						0: pins_now ^= 32'd1 << $urandom_range(0, 31);
						1: pins_now ^= $urandom & $urandom;
						default: pins_now = $urandom;
					endcase
				end
				issue_word(op, pins_now, $urandom, 1'b0, '0);
			end
		end
		steady = 1'b0;

		drain_port();
		repeat (4) @(negedge clk);
		if (mismatches == 0)
			$display("gpio_edge_level_irq_port_core regression: pass");
		else
			$display("gpio_edge_level_irq_port_core regression: fail");
		$finish;
	end

endmodule

>>> gpio_edge_level_irq_port_core.f
+incdir+hdl
hdl/gpioeli_pkg.sv
hdl/gpioeli_if.sv
hdl/gpioeli_lane.sv
hdl/gpioeli_merge.sv
hdl/gpio_edge_level_irq_port_core.sv
tb/tb_gpio_edge_level_irq_port_core.sv
